[rtl/core/rsec_pkg.sv]
// rsec_pkg: widths, sizes and instruction codes of the execute core.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package rsec_pkg;

   localparam int XLEN            = 32;
   localparam int NUM_REGS        = 32;
   localparam int REG_IDX_W       = 5;
   localparam int DATA_WORDS      = 16;
   localparam int DATA_IDX_W      = 4;
   localparam logic [XLEN-1:0] STORE_BYTES     = XLEN'(4 * DATA_WORDS);
   localparam logic [XLEN-1:0] DATA_BASE_RESET = 32'd128;

   typedef enum logic {
      OP_EXEC    = 1'b0,
      OP_PRELOAD = 1'b1
   } req_op_type;

   // instruction category, bits 31:30
   typedef enum logic [1:0] {
      CAT_CTRL = 2'b00,
      CAT_REG  = 2'b01,
      CAT_IMM  = 2'b10,
      CAT_NONE = 2'b11
   } cat_type;

   // control category opcode, bits 29:26
   typedef enum logic [3:0] {
      OPC_J     = 4'h0,
      OPC_BEQ   = 4'h2,
      OPC_BGTZ  = 4'h4,
      OPC_BREAK = 4'h5,
      OPC_SW    = 4'h6,
      OPC_LW    = 4'h7
   } ctrl_opc_type;

   // register category opcode, bits 19:16
   typedef enum logic [3:0] {
      ALU_ADD = 4'h0,
      ALU_SUB = 4'h1,
      ALU_MUL = 4'h2,
      ALU_AND = 4'h3,
      ALU_OR  = 4'h4,
      ALU_XOR = 4'h5,
      ALU_NOR = 4'h6
   } alu_opc_type;

   // immediate category opcode, bits 19:16
   typedef enum logic [3:0] {
      IMM_ADDI = 4'h0,
      IMM_ANDI = 4'h1,
      IMM_ORI  = 4'h2,
      IMM_XORI = 4'h3
   } imm_opc_type;

endpackage

[rtl/core/rsec_channels.sv]
// rsec channel interfaces: request, response and CSR write channels.
// Depends on rsec_pkg for field widths.
`timescale 1ns / 1ps

interface rsec_req_if;
   import rsec_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [XLEN-1:0]             instr_word;
   logic [XLEN-1:0]             pc;
   logic [DATA_IDX_W-1:0]       load_index;
   logic signed [XLEN-1:0]      load_value;

   modport source (output valid, op, instr_word, pc, load_index, load_value, input ready);
   modport sink   (input valid, op, instr_word, pc, load_index, load_value, output ready);
endinterface

interface rsec_rsp_if;
   import rsec_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [XLEN-1:0]             next_pc;
   logic                        halted;
   logic                        reg_write;
   logic [REG_IDX_W-1:0]        reg_index;
   logic signed [XLEN-1:0]      reg_value;
   logic                        mem_write;
   logic [DATA_IDX_W-1:0]       mem_index;
   logic signed [XLEN-1:0]      mem_value;
   logic                        addr_error;

   modport source (output valid, next_pc, halted, reg_write, reg_index, reg_value,
                   mem_write, mem_index, mem_value, addr_error, input ready);
   modport sink   (input valid, next_pc, halted, reg_write, reg_index, reg_value,
                   mem_write, mem_index, mem_value, addr_error, output ready);
endinterface

interface rsec_csr_if;
   import rsec_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [XLEN-1:0]             data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[rtl/core/risc_subset_execute_core.sv]
// risc_subset_execute_core: executes one instruction (or a data preload) per beat.
// Request captured in stage A, result held in the response register; throughput 1 beat/cycle
//   while rsp is ready, set by the input stage -> execute logic -> response register path.
// Register file: 32x32 RAM, two registered read ports at accept, bypass from writeback.
// Reset (sync, high): pipe empty, data_base = 128, reg file and data store read as 0.
// Depends on rsec_pkg and rsec_channels.sv.
`timescale 1ns / 1ps

module risc_subset_execute_core (
   input  logic        clock,
   input  logic        reset,
   rsec_req_if.sink    req_if,
   rsec_rsp_if.source  rsp_if,
   rsec_csr_if.sink    csr_if
);
   import rsec_pkg::*;

   // ------------------------------------------------------------------
   // Handshake control
   //   stage A : captured request + register file read data
   //   stage R : response register
   // A beat moves A->R when R is empty or being drained this cycle.
   // ------------------------------------------------------------------
   logic va_ff;             // stage A holds a beat
   logic vo_ff;             // response register holds a beat
   logic accept;
   logic advance;

   assign advance      = va_ff && (!vo_ff || rsp_if.ready);
   assign req_if.ready = !va_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   // CSR: data_base, always writable
   logic [XLEN-1:0] data_base_ff;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_base_ff <= DATA_BASE_RESET;
      end else if (csr_if.valid) begin
         data_base_ff <= csr_if.data;
      end
   end

   // ------------------------------------------------------------------
   // Stage A payload
   // ------------------------------------------------------------------
   logic                  op_ff;
   logic [XLEN-1:0]       iw_ff;
   logic [XLEN-1:0]       pc_ff;
   logic [DATA_IDX_W-1:0] lidx_ff;
   logic [XLEN-1:0]       lval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (accept) begin
         va_ff <= 1'b1;
      end else if (advance) begin
         va_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_if.op;
         iw_ff   <= req_if.instr_word;
         pc_ff   <= req_if.pc;
         lidx_ff <= req_if.load_index;
         lval_ff <= $unsigned(req_if.load_value);
      end
   end

   // ------------------------------------------------------------------
   // Register file: RAM with valid bits (unwritten entries read as zero)
   // and a bypass for the write retiring in the same cycle as the read.
   // Port A: rs (control category uses bits 25:21), port B: rt.
   // ------------------------------------------------------------------
   logic [XLEN-1:0]      rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0]  rf_vld_ff;
   logic [XLEN-1:0]      rf_a_raw_ff, rf_b_raw_ff;
   logic                 vld_a_ff, vld_b_ff;
   logic                 byp_a_ff, byp_b_ff;
   logic [XLEN-1:0]      byp_data_ff;
   logic [REG_IDX_W-1:0] ra, rb;
   logic                 req_is_ctrl;

   // writeback from the execute logic (stage A beat that advances)
   logic                  reg_write_in;
   logic [REG_IDX_W-1:0]  reg_index_in;
   logic [XLEN-1:0]       reg_value_in;
   logic                  rf_we;
   logic                  byp_a_in, byp_b_in;

   assign req_is_ctrl = (cat_type'(req_if.instr_word[31:30]) == CAT_CTRL);
   assign ra          = req_is_ctrl ? req_if.instr_word[25:21] : req_if.instr_word[29:25];
   assign rb          = req_is_ctrl ? req_if.instr_word[20:16] : req_if.instr_word[24:20];
   assign rf_we       = advance && reg_write_in;
   assign byp_a_in    = rf_we && (reg_index_in == ra);
   assign byp_b_in    = rf_we && (reg_index_in == rb);

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[reg_index_in] <= reg_value_in;
      end
      if (accept) begin
         rf_a_raw_ff <= rf_mem[ra];
         rf_b_raw_ff <= rf_mem[rb];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (rf_we) begin
         rf_vld_ff[reg_index_in] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vld_a_ff    <= rf_vld_ff[ra];
         vld_b_ff    <= rf_vld_ff[rb];
         byp_a_ff    <= byp_a_in;
         byp_b_ff    <= byp_b_in;
         byp_data_ff <= reg_value_in;
      end
   end

   logic [XLEN-1:0] opa, opb;
   assign opa = byp_a_ff ? byp_data_ff : (vld_a_ff ? rf_a_raw_ff : '0);
   assign opb = byp_b_ff ? byp_data_ff : (vld_b_ff ? rf_b_raw_ff : '0);

   // ------------------------------------------------------------------
   // Data store: 16 words in flops, one read port (LW), one write port.
   // ------------------------------------------------------------------
   logic [XLEN-1:0] ds_ff [DATA_WORDS];

   // ------------------------------------------------------------------
   // Execute
   // ------------------------------------------------------------------
   logic [XLEN-1:0]       pc4;
   logic [15:0]           off;
   logic [XLEN-1:0]       br_tgt;
   logic [XLEN-1:0]       daddr;
   logic                  in_range;
   logic [DATA_IDX_W-1:0] didx;
   logic [XLEN-1:0]       mul_lo;
   logic [XLEN-1:0]       next_pc_in;
   logic                  halted_in;
   logic                  mem_write_in;
   logic [DATA_IDX_W-1:0] mem_index_in;
   logic [XLEN-1:0]       mem_value_in;
   logic                  addr_error_in;

   assign pc4      = pc_ff + 32'd4;
   assign off      = iw_ff[15:0];
   assign br_tgt   = pc4 + {14'd0, off, 2'b00};
   // offset zero-extended; below-base addresses wrap high and fail the range check
   assign daddr    = {16'd0, off} + opa - data_base_ff;
   assign in_range = (daddr < STORE_BYTES);
   assign didx     = daddr[DATA_IDX_W+1:2];
   assign mul_lo   = XLEN'(opa * opb);

   always_comb begin
      next_pc_in    = pc4;
      halted_in     = 1'b0;
      reg_write_in  = 1'b0;
      reg_index_in  = '0;
      reg_value_in  = '0;
      mem_write_in  = 1'b0;
      mem_index_in  = '0;
      mem_value_in  = '0;
      addr_error_in = 1'b0;

      if (req_op_type'(op_ff) == OP_PRELOAD) begin
         next_pc_in = pc_ff;
         if (32'(lidx_ff) < 32'(DATA_WORDS)) begin
            mem_write_in = 1'b1;
            mem_index_in = lidx_ff;
            mem_value_in = lval_ff;
         end else begin
            addr_error_in = 1'b1;
         end
      end else begin
         case (cat_type'(iw_ff[31:30]))
            CAT_CTRL: begin
               case (ctrl_opc_type'(iw_ff[29:26]))
                  OPC_J: begin
                     next_pc_in = {iw_ff[29:0], 2'b00} & 32'h0FFF_FFFC;
                  end
                  OPC_BEQ: begin
                     if (opa == opb) begin
                        next_pc_in = br_tgt;
                     end
                  end
                  OPC_BGTZ: begin
                     if ((opa != '0) && !opa[XLEN-1]) begin
                        next_pc_in = br_tgt;
                     end
                  end
                  OPC_BREAK: begin
                     halted_in = 1'b1;
                  end
                  OPC_SW: begin
                     if (in_range) begin
                        mem_write_in = 1'b1;
                        mem_index_in = didx;
                        mem_value_in = opb;
                     end else begin
                        addr_error_in = 1'b1;
                     end
                  end
                  OPC_LW: begin
                     if (in_range) begin
                        reg_write_in = 1'b1;
                        reg_index_in = iw_ff[20:16];
                        reg_value_in = ds_ff[didx];
                     end else begin
                        addr_error_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            CAT_REG: begin
               reg_write_in = 1'b1;
               reg_index_in = iw_ff[15:11];
               case (alu_opc_type'(iw_ff[19:16]))
                  ALU_ADD: reg_value_in = opa + opb;
                  ALU_SUB: reg_value_in = opa - opb;
                  ALU_MUL: reg_value_in = mul_lo;
                  ALU_AND: reg_value_in = opa & opb;
                  ALU_OR:  reg_value_in = opa | opb;
                  ALU_XOR: reg_value_in = opa ^ opb;
                  ALU_NOR: reg_value_in = ~(opa | opb);
                  default: begin
                     reg_write_in = 1'b0;
                     reg_index_in = '0;
                  end
               endcase
            end
            CAT_IMM: begin
               reg_write_in = 1'b1;
               reg_index_in = iw_ff[24:20];
               case (imm_opc_type'(iw_ff[19:16]))
                  IMM_ADDI: reg_value_in = opa + {16'd0, off};
                  IMM_ANDI: reg_value_in = opa & {16'd0, off};
                  IMM_ORI:  reg_value_in = opa | {16'd0, off};
                  IMM_XORI: reg_value_in = opa ^ {16'd0, off};
                  default: begin
                     reg_write_in = 1'b0;
                     reg_index_in = '0;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_ff <= '{default: '0};
      end else if (advance && mem_write_in) begin
         ds_ff[mem_index_in] <= mem_value_in;
      end
   end

   // ------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------
   logic [XLEN-1:0]        next_pc_ff;
   logic                   halted_ff;
   logic                   reg_write_ff;
   logic [REG_IDX_W-1:0]   reg_index_ff;
   logic [XLEN-1:0]        reg_value_ff;
   logic                   mem_write_ff;
   logic [DATA_IDX_W-1:0]  mem_index_ff;
   logic [XLEN-1:0]        mem_value_ff;
   logic                   addr_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (advance) begin
         vo_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         vo_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         next_pc_ff    <= next_pc_in;
         halted_ff     <= halted_in;
         reg_write_ff  <= reg_write_in;
         reg_index_ff  <= reg_index_in;
         reg_value_ff  <= reg_value_in;
         mem_write_ff  <= mem_write_in;
         mem_index_ff  <= mem_index_in;
         mem_value_ff  <= mem_value_in;
         addr_error_ff <= addr_error_in;
      end
   end

   assign rsp_if.valid      = vo_ff;
   assign rsp_if.next_pc    = next_pc_ff;
   assign rsp_if.halted     = halted_ff;
   assign rsp_if.reg_write  = reg_write_ff;
   assign rsp_if.reg_index  = reg_index_ff;
   assign rsp_if.reg_value  = $signed(reg_value_ff);
   assign rsp_if.mem_write  = mem_write_ff;
   assign rsp_if.mem_index  = mem_index_ff;
   assign rsp_if.mem_value  = $signed(mem_value_ff);
   assign rsp_if.addr_error = addr_error_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_ready_when_a_empty: assert property (@(posedge clock) disable iff (reset)
      !va_ff |-> req_if.ready)
      else $error("req not ready with stage A empty");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (va_ff && vo_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("req accepted while pipe stalled");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> vo_ff)
      else $error("advanced beat missing from response register");

   a_halt_no_write: assert property (@(posedge clock) disable iff (reset)
      (vo_ff && halted_ff) |-> (!reg_write_ff && !mem_write_ff))
      else $error("BREAK produced a write");

   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      (vo_ff && addr_error_ff) |-> (!reg_write_ff && !mem_write_ff))
      else $error("address error produced a write");

endmodule

[bench/rsec_retire_checker.sv]
// rsec_retire_checker: watches the request, response and CSR channels of the execute core,
// predicts each retired beat from its own register file and data store, and counts mismatches.
// Depends on rsec_pkg and the channel interfaces in rsec_channels.sv.
`timescale 1ns / 1ps

module rsec_retire_checker
   import rsec_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rsec_req_if  req_mon,
   rsec_rsp_if  rsp_mon,
   rsec_csr_if  csr_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic [XLEN-1:0]       next_pc;
      logic                  halted;
      logic                  reg_write;
      logic [REG_IDX_W-1:0]  reg_index;
      logic [XLEN-1:0]       reg_value;
      logic                  mem_write;
      logic [DATA_IDX_W-1:0] mem_index;
      logic [XLEN-1:0]       mem_value;
      logic                  addr_error;
   } retire_type;

   logic [XLEN-1:0] regs [NUM_REGS];
   logic [XLEN-1:0] dmem [DATA_WORDS];
   logic [XLEN-1:0] data_base;
   retire_type      pending_retires [$];
   int              errors = 0;

   assign fail_count = errors;

   // executes one beat against the shadow state and returns what the core should report
   function automatic retire_type retire(input logic op, input logic [XLEN-1:0] iw,
                                         input logic [XLEN-1:0] pc,
                                         input logic [DATA_IDX_W-1:0] lidx,
                                         input logic [XLEN-1:0] lval);
      retire_type      r;
      logic [XLEN-1:0] x, y, ea, res;
      logic [15:0]     off;
      logic [4:0]      a, b;
      logic            wr;
      r = '0;
      r.next_pc = pc + 32'd4;
      if (req_op_type'(op) == OP_PRELOAD) begin
         r.next_pc = pc;
         if (int'(lidx) < DATA_WORDS) begin
            dmem[lidx] = lval;
            r.mem_write = 1'b1;
            r.mem_index = lidx;
            r.mem_value = lval;
         end else begin
            r.addr_error = 1'b1;
         end
         return r;
      end
      case (cat_type'(iw[31:30]))
         CAT_CTRL: begin
            a   = iw[25:21];
            b   = iw[20:16];
            off = iw[15:0];
            // unsigned wrap: below data_base lands far above the store
            ea  = {16'h0, off} + regs[a] - data_base;
            case (ctrl_opc_type'(iw[29:26]))
               OPC_J:     r.next_pc = {4'h0, iw[25:0], 2'b00};
               OPC_BEQ:   if (regs[a] == regs[b])
                             r.next_pc = pc + 32'd4 + {14'h0, off, 2'b00};
               OPC_BGTZ:  if (regs[a] != '0 && !regs[a][XLEN-1])
                             r.next_pc = pc + 32'd4 + {14'h0, off, 2'b00};
               OPC_BREAK: r.halted = 1'b1;
               OPC_SW: begin
                  if (ea < STORE_BYTES) begin
                     dmem[ea[DATA_IDX_W+1:2]] = regs[b];
                     r.mem_write = 1'b1;
                     r.mem_index = DATA_IDX_W'(ea >> 2);
                     r.mem_value = regs[b];
                  end else begin
                     r.addr_error = 1'b1;
                  end
               end
               OPC_LW: begin
                  if (ea < STORE_BYTES) begin
                     regs[b] = dmem[ea[DATA_IDX_W+1:2]];
                     r.reg_write = 1'b1;
                     r.reg_index = b;
                     r.reg_value = regs[b];
                  end else begin
                     r.addr_error = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         CAT_REG: begin
            x  = regs[iw[29:25]];
            y  = regs[iw[24:20]];
            wr = 1'b1;
            case (alu_opc_type'(iw[19:16]))
               ALU_ADD: res = x + y;
               ALU_SUB: res = x - y;
               ALU_MUL: res = x * y;
               ALU_AND: res = x & y;
               ALU_OR:  res = x | y;
               ALU_XOR: res = x ^ y;
               ALU_NOR: res = ~(x | y);
               default: wr = 1'b0;
            endcase
            if (wr) begin
               regs[iw[15:11]] = res;
               r.reg_write = 1'b1;
               r.reg_index = iw[15:11];
               r.reg_value = res;
            end
         end
         CAT_IMM: begin
            x  = regs[iw[29:25]];
            y  = {16'h0, iw[15:0]};
            wr = 1'b1;
            case (imm_opc_type'(iw[19:16]))
               IMM_ADDI: res = x + y;
               IMM_ANDI: res = x & y;
               IMM_ORI:  res = x | y;
               IMM_XORI: res = x ^ y;
               default:  wr = 1'b0;
            endcase
            if (wr) begin
               regs[iw[24:20]] = res;
               r.reg_write = 1'b1;
               r.reg_index = iw[24:20];
               r.reg_value = res;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void cmp_field(input string name, input logic [XLEN-1:0] want,
                                     input logic [XLEN-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      retire_type want;
      retire_type predicted;
      if (reset) begin
         data_base = DATA_BASE_RESET;
         foreach (regs[i]) regs[i] = '0;
         foreach (dmem[i]) dmem[i] = '0;
         pending_retires.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_retires.size() == 0) begin
               $display("%0t: response beat with nothing outstanding, expected none, actual next_pc %h",
                        $time, rsp_mon.next_pc);
               errors++;
            end else begin
               want = pending_retires.pop_front();
               cmp_field("next_pc",    want.next_pc,    rsp_mon.next_pc);
               cmp_field("halted",     want.halted,     rsp_mon.halted);
               cmp_field("reg_write",  want.reg_write,  rsp_mon.reg_write);
               cmp_field("reg_index",  want.reg_index,  rsp_mon.reg_index);
               cmp_field("reg_value",  want.reg_value,  rsp_mon.reg_value);
               cmp_field("mem_write",  want.mem_write,  rsp_mon.mem_write);
               cmp_field("mem_index",  want.mem_index,  rsp_mon.mem_index);
               cmp_field("mem_value",  want.mem_value,  rsp_mon.mem_value);
               cmp_field("addr_error", want.addr_error, rsp_mon.addr_error);
            end
         end
         if (csr_mon.valid && csr_mon.ready)
            data_base = csr_mon.data;
         if (req_mon.valid && req_mon.ready) begin
            predicted = retire(req_mon.op, req_mon.instr_word, req_mon.pc,
                               req_mon.load_index, req_mon.load_value);
            pending_retires = {pending_retires, predicted};
         end
      end
      pending <= pending_retires.size();
   end

endmodule

[bench/testbench.sv]
// testbench: stimulus and verdict for risc_subset_execute_core.
// Drives request, CSR and response-ready; rsec_retire_checker does all prediction and compare.
// Depends on rsec_pkg, rsec_channels.sv, the core RTL and rsec_retire_checker.sv.
`timescale 1ns / 1ps

module testbench;
   import rsec_pkg::*;

   logic            clock;
   logic            reset;
   int              fail_count;
   int              pending;      // beats accepted but not yet answered
   logic            no_idle = 1'b0;
   int              rsp_hold = 0;
   int              item_count = 0;
   logic [XLEN-1:0] csr_base;     // data_base as last written, used to aim loads/stores

   rsec_req_if req_if ();
   rsec_rsp_if rsp_if ();
   rsec_csr_if csr_if ();

   risc_subset_execute_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   rsec_retire_checker retire_chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_mon    (csr_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Response side: ready mostly high, short stalls often, long ones rarely.
   // no_idle turns stalls off so some stretches run at full rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= 0;
      end else if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= rsp_hold - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!no_idle) begin
            case ($urandom_range(0, 99))
               0, 1, 2:  rsp_hold <= $urandom_range(8, 40);
               3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16:
                         rsp_hold <= $urandom_range(1, 3);
               default:  rsp_hold <= 0;
            endcase
         end
      end
   end

   // Hard stop. Slowest legal run is ~1200 beats, each with the longest gap and stall, ~ 1 ms;
   // 20 ms leaves plenty of margin.
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---- instruction encoders -------------------------------------------------

   function automatic logic [XLEN-1:0] enc_ctrl(input logic [3:0] opc, input logic [4:0] a,
                                                input logic [4:0] b, input logic [15:0] off);
      return {CAT_CTRL, opc, a, b, off};
   endfunction

   function automatic logic [XLEN-1:0] enc_jump(input logic [25:0] target);
      return {CAT_CTRL, OPC_J, target};
   endfunction

   // bits 10:0 are unused by the core; fill them with noise
   function automatic logic [XLEN-1:0] enc_reg(input logic [3:0] opc, input logic [4:0] rs,
                                               input logic [4:0] rt, input logic [4:0] rd);
      logic [10:0] junk;
      junk = 11'($urandom);
      return {CAT_REG, rs, rt, opc, rd, junk};
   endfunction

   function automatic logic [XLEN-1:0] enc_imm(input logic [3:0] opc, input logic [4:0] rs,
                                               input logic [4:0] rt, input logic [15:0] imm);
      return {CAT_IMM, rs, rt, opc, imm};
   endfunction

   // random word biased toward the corners
   function automatic logic [XLEN-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic int gap_len();
      if (no_idle) return 0;
      case ($urandom_range(0, 99))
         0, 1, 2, 3, 4, 5, 6: return $urandom_range(8, 40);
         default: begin
            if ($urandom_range(0, 99) < 30) return $urandom_range(1, 3);
            return 0;
         end
      endcase
   endfunction

   // ---- request driving ------------------------------------------------------

   // Drives one beat and returns right after the edge that takes it. valid stays
   // high into the next beat unless a gap is picked, so it is never dropped and
   // raised within one step.
   task automatic send(input req_op_type op, input logic [XLEN-1:0] iw,
                       input logic [XLEN-1:0] pc, input logic [DATA_IDX_W-1:0] lidx,
                       input logic [XLEN-1:0] lval);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.op         <= op;
      req_if.instr_word <= iw;
      req_if.pc         <= pc;
      req_if.load_index <= lidx;
      req_if.load_value <= lval;
      do @(posedge clock); while (!req_if.ready);
      item_count++;
   endtask

   // execute beat; preload fields carry noise
   task automatic exec(input logic [XLEN-1:0] iw);
      send(OP_EXEC, iw, pick_word(), DATA_IDX_W'($urandom), $urandom);
   endtask

   // Stop sending, wait until every beat is answered, then let the pipe settle.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_base(input logic [XLEN-1:0] value);
      drain();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      csr_base = value;
   endtask

   // Build a full 32-bit constant in r using scratch s (r != s):
   // s = 0x10000, r = hi * s | lo.
   task automatic load_const(input logic [4:0] r, input logic [4:0] s,
                             input logic [XLEN-1:0] value);
      exec(enc_imm(IMM_ANDI, s, s, 16'h0000));
      exec(enc_imm(IMM_ORI,  s, s, 16'h8000));
      exec(enc_reg(ALU_ADD,  s, s, s));
      exec(enc_imm(IMM_ANDI, r, r, 16'h0000));
      exec(enc_imm(IMM_ORI,  r, r, value[31:16]));
      exec(enc_reg(ALU_MUL,  r, s, r));
      exec(enc_imm(IMM_ORI,  r, r, value[15:0]));
   endtask

   // Aim a base register at a chosen byte of the store, then SW and maybe LW
   // through it. Some targets are deliberately just outside or below the store.
   task automatic mem_sequence();
      logic [4:0]      rb, rs, rd;
      logic [15:0]     off;
      logic [XLEN-1:0] target;
      rb = 5'($urandom);
      do rs = 5'($urandom); while (rs == rb);
      rd  = 5'($urandom);
      off = 16'($urandom);
      if ($urandom_range(0, 99) < 85)
         target = $urandom_range(0, 4 * DATA_WORDS - 1);
      else if ($urandom_range(0, 1) == 0)
         target = 4 * DATA_WORDS + $urandom_range(0, 200);
      else
         target = 32'h0 - $urandom_range(1, 100);
      load_const(rb, rs, csr_base + target - {16'h0, off});
      exec(enc_ctrl(OPC_SW, rb, rd, off));
      if ($urandom_range(0, 1) == 1)
         exec(enc_ctrl(OPC_LW, rb, 5'($urandom), off));
   endtask

   // Corner cases with the reset state: all registers zero, data_base 128.
   task automatic directed_items();
      send(OP_PRELOAD, $urandom, 32'h0000_0000, 4'd0,  32'h7FFF_FFFF);
      send(OP_PRELOAD, $urandom, 32'hFFFF_FFFF, 4'd15, 32'h8000_0000);
      // next_pc wraps to zero
      send(OP_EXEC, enc_imm(IMM_ADDI, 0, 1, 16'hFFFF), 32'hFFFF_FFFC, 4'd0, 32'h0);
      exec(enc_imm(IMM_ORI,  0, 2, 16'h8000));
      exec(enc_imm(IMM_ANDI, 1, 3, 16'h00FF));
      exec(enc_imm(IMM_XORI, 1, 4, 16'hFFFF));
      exec(enc_reg(ALU_ADD, 1, 2, 5));
      exec(enc_reg(ALU_SUB, 0, 1, 6));       // goes negative
      exec(enc_reg(ALU_MUL, 1, 1, 7));
      exec(enc_reg(ALU_AND, 1, 2, 8));
      exec(enc_reg(ALU_OR,  1, 2, 9));
      exec(enc_reg(ALU_XOR, 1, 3, 10));
      exec(enc_reg(ALU_NOR, 0, 0, 11));      // all ones
      exec(enc_jump(26'h3FF_FFFF));
      // taken with the largest offset, target wraps
      send(OP_EXEC, enc_ctrl(OPC_BEQ, 0, 4, 16'hFFFF), 32'hFFFF_FFF0, 4'd0, 32'h0);
      exec(enc_ctrl(OPC_BEQ,  1, 2, 16'h1234));
      exec(enc_ctrl(OPC_BGTZ, 1, 0, 16'h0040));
      exec(enc_ctrl(OPC_BGTZ, 11, 0, 16'h0040));
      exec(enc_ctrl(OPC_BREAK, 5'($urandom), 5'($urandom), 16'($urandom)));
      exec(enc_ctrl(OPC_SW, 0, 1, 16'd188));   // last word
      exec(enc_ctrl(OPC_LW, 0, 12, 16'd128));  // first word
      exec(enc_ctrl(OPC_LW, 0, 12, 16'd0));    // below the store
      exec(enc_ctrl(OPC_SW, 0, 1, 16'd192));   // one past the end
      exec(enc_ctrl(4'hF, 5'($urandom), 5'($urandom), 16'($urandom)));
      exec(enc_reg(4'h7, 5'($urandom), 5'($urandom), 5'($urandom)));
      exec(enc_imm(4'h4, 5'($urandom), 5'($urandom), 16'($urandom)));
      exec({CAT_NONE, 30'($urandom)});
   endtask

   // One random step: mostly well-formed work, some noise.
   task automatic random_step();
      logic [4:0] a, b;
      logic [3:0] opc;
      int         kind;
      a    = 5'($urandom);
      b    = 5'($urandom);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         mem_sequence();
      end else if (kind < 47) begin
         opc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(7, 15))
                                           : 4'($urandom_range(0, 6));
         exec(enc_reg(opc, a, b, 5'($urandom)));
      end else if (kind < 62) begin
         opc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(4, 15))
                                           : 4'($urandom_range(0, 3));
         exec(enc_imm(opc, a, b, 16'(pick_word())));
      end else if (kind < 67) begin
         if (a == b) b = a + 5'd1;
         load_const(a, b, pick_word());
      end else if (kind < 77) begin
         case ($urandom_range(0, 2))
            0:       exec(enc_jump(26'($urandom)));
            1:       exec(enc_ctrl(OPC_BEQ, a, ($urandom_range(0, 1) == 1) ? a : b,
                                   16'($urandom)));
            default: exec(enc_ctrl(OPC_BGTZ, a, b, 16'($urandom)));
         endcase
      end else if (kind < 86) begin
         send(OP_PRELOAD, $urandom, pick_word(),
              DATA_IDX_W'($urandom_range(0, DATA_WORDS - 1)), pick_word());
      end else if (kind < 91) begin
         case ($urandom_range(0, 3))
            0:       exec(enc_ctrl(OPC_BREAK, a, b, 16'($urandom)));
            1:       exec(enc_ctrl(4'($urandom_range(8, 15)), a, b, 16'($urandom)));
            2:       exec(enc_ctrl(($urandom_range(0, 1) == 1) ? 4'h1 : 4'h3, a, b,
                                   16'($urandom)));
            default: exec({CAT_NONE, 30'($urandom)});
         endcase
      end else begin
         // raw noise on every field
         send(req_op_type'($urandom_range(0, 1)), $urandom, $urandom,
              DATA_IDX_W'($urandom), $urandom);
      end
   endtask

   initial begin
      logic [XLEN-1:0] phase_base;
      int              phase_start;
      logic            mid_drained;
      req_if.valid      <= 1'b0;
      req_if.op         <= OP_EXEC;
      req_if.instr_word <= '0;
      req_if.pc         <= '0;
      req_if.load_index <= '0;
      req_if.load_value <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.data       <= '0;
      csr_base = DATA_BASE_RESET;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_items();

      // data_base sweep: zero, all ones, just below wrap, random, back to reset value
      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       phase_base = 32'h0000_0000;
            1:       phase_base = 32'hFFFF_FFFF;
            2:       phase_base = 32'hFFFF_FFC0;
            3:       phase_base = $urandom;
            default: phase_base = DATA_BASE_RESET;
         endcase
         write_base(phase_base);
         phase_start = item_count;
         mid_drained = 1'b0;
         while (item_count < phase_start + 225) begin
            // a back-to-back stretch with no gaps and no stalls
            no_idle = (item_count >= phase_start + 60) && (item_count < phase_start + 100);
            // halfway: let the pipe run completely dry before carrying on
            if (!mid_drained && item_count >= phase_start + 112) begin
               drain();
               mid_drained = 1'b1;
            end
            random_step();
         end
         no_idle = 1'b0;
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/core/rsec_pkg.sv
rtl/core/rsec_channels.sv
rtl/core/risc_subset_execute_core.sv
bench/rsec_retire_checker.sv
bench/testbench.sv
